// File: src/abf_pkg.sv
// shared types and constants of the ac3 burst framer
`default_nettype none
package abf_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned REP_W    = 14;
  localparam int unsigned MINB_W   = 15;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [WORD_W-1:0] SYNC_A = 16'hF872;
  localparam logic [WORD_W-1:0] SYNC_B = 16'h4E1F;
  localparam logic [WORD_W-1:0] BURST_ROUND = 16'd2047;
  localparam logic [13:0]       HEADER_BYTES = 14'd16;

  localparam logic [WORD_W-1:0] PC_RESET   = 16'd1;
  localparam logic [MINB_W-1:0] MINB_RESET = 15'd6144;

  // register indexes of the configuration port
  localparam logic REG_PC_WORD   = 1'b0;
  localparam logic REG_MIN_BURST = 1'b1;

  // back end sequence positions: header words 0..7, then data, then padding
  localparam logic [STEP_W-1:0] STEP_HDR_FIRST = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SYNC_A    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SYNC_B    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_PC        = 4'd6;
  localparam logic [STEP_W-1:0] STEP_HDR_LAST  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DATA      = 4'd8;
  localparam logic [STEP_W-1:0] STEP_PAD       = 4'd9;

  // one classified input item as it travels through the queue
  typedef struct packed {
    logic              first;
    logic [WORD_W-1:0] pc;
    logic [WORD_W-1:0] len_bits;
    logic              has_word;
    logic [WORD_W-1:0] word;
    logic              last;
    logic              pad_en;
    logic [REP_W-1:0]  pad;
  } abf_rec_t;

endpackage
`default_nettype wire

// File: src/abf_front.sv
// front end: config registers, frame position tracking, item classification
`default_nettype none
module abf_front
  import abf_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 8191
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [WORD_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic [LEN_W-1:0]  frame_bytes,
  input  wire logic              q_full,
  output      logic              q_push,
  output      abf_rec_t          q_rec
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);

  logic [WORD_W-1:0] pc_word;
  logic [MINB_W-1:0] min_burst_bytes;
  logic [LEN_W-1:0]  bytes_seen;
  logic [LEN_W-1:0]  frame_length;
  logic [BYTE_W-1:0] held_byte;

  logic              first;
  logic [LEN_W-1:0]  fl_sat;
  logic [LEN_W-1:0]  fl;
  logic [LEN_W:0]    pos_p1;
  logic              last;
  logic              odd;
  logic [13:0]       fl_p1;
  logic [13:0]       need;
  logic [15:0]       need_up;
  logic [15:0]       min_up;
  logic [15:0]       len_unit;
  logic [15:0]       len_min;
  logic [15:0]       burst_len;
  logic [15:0]       pad_wide;
  logic              accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  assign first  = (bytes_seen == '0);
  always_comb begin
    if (frame_bytes == '0) begin
      fl_sat = LEN_W'(1);
    end else if (frame_bytes > MAX_LEN) begin
      fl_sat = MAX_LEN;
    end else begin
      fl_sat = frame_bytes;
    end
  end
  assign fl     = first ? fl_sat : frame_length;
  assign pos_p1 = {1'b0, bytes_seen} + (LEN_W+1)'(1);
  assign last   = (pos_p1 >= {1'b0, fl});
  assign odd    = bytes_seen[0];

  // burst length: max(min burst, even payload+header) up to whole 2048 byte units
  assign fl_p1     = {1'b0, fl} + 14'd1;
  assign need      = {fl_p1[13:1], 1'b0} + HEADER_BYTES;
  assign need_up   = {2'b00, need} + BURST_ROUND;
  assign min_up    = {1'b0, min_burst_bytes} + BURST_ROUND;
  assign len_unit  = {need_up[15:11], 11'd0};
  assign len_min   = {min_up[15:11], 11'd0};
  assign burst_len = (len_min > len_unit) ? len_min : len_unit;
  assign pad_wide  = (burst_len - {2'b00, need}) >> 1;

  always_comb begin
    q_rec.first    = first;
    q_rec.pc       = pc_word;
    q_rec.len_bits = {fl, 3'b000};
    q_rec.has_word = odd || last;
    q_rec.word     = odd ? {held_byte, data_byte} : {data_byte, 8'h00};
    q_rec.last     = last;
    q_rec.pad      = pad_wide[REP_W-1:0];
    q_rec.pad_en   = last && (pad_wide != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc_word         <= PC_RESET;
      min_burst_bytes <= MINB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PC_WORD:   pc_word         <= cfg_data;
        REG_MIN_BURST: min_burst_bytes <= cfg_data[MINB_W-1:0];
        default:       pc_word         <= pc_word;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen   <= '0;
      frame_length <= '0;
      held_byte    <= '0;
    end else if (accept) begin
      if (first) begin
        frame_length <= fl_sat;
      end
      if (!odd && !last) begin
        held_byte <= data_byte;
      end
      bytes_seen <= last ? '0 : pos_p1[LEN_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: src/abf_fifo.sv
// short queue of classified items between front and back end
`default_nettype none
module abf_fifo
  import abf_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire abf_rec_t push_rec,
  output      logic     full,
  input  wire logic     pop,
  output      logic     empty,
  output      abf_rec_t pop_rec
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  abf_rec_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: src/abf_back.sv
// back end: expands each queued item into header, data and padding results
`default_nettype none
module abf_back
  import abf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire abf_rec_t          q_rec,
  output      logic              q_pop,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [WORD_W-1:0] out_word,
  output      logic [REP_W-1:0]  out_rep,
  output      logic              out_eob,
  output      logic              out_eor
);

  abf_rec_t          cur;
  logic              cur_valid;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [STEP_W-1:0] load_step;
  logic              emit;
  logic              cur_final;
  logic              load;
  logic              q_any;
  logic [WORD_W-1:0] emit_word;
  logic [REP_W-1:0]  emit_rep;

  assign emit = cur_valid && (!out_valid || out_ready);

  always_comb begin
    cur_final = (step == STEP_PAD) ||
                ((step == STEP_DATA) && !cur.pad_en) ||
                ((step == STEP_HDR_LAST) && !cur.has_word && !cur.pad_en);
  end

  // a held byte without header gives no result and is dropped on load
  assign q_any     = q_rec.first || q_rec.has_word || q_rec.pad_en;
  assign load      = !q_empty && (!cur_valid || (emit && cur_final));
  assign q_pop     = load;
  assign load_step = q_rec.first ? STEP_HDR_FIRST : (q_rec.has_word ? STEP_DATA : STEP_PAD);

  always_comb begin
    if (step == STEP_HDR_LAST) begin
      step_next = cur.has_word ? STEP_DATA : STEP_PAD;
    end else begin
      step_next = step + STEP_W'(1);
    end
  end

  always_comb begin
    emit_rep = REP_W'(1);
    unique case (step)
      STEP_SYNC_A:   emit_word = SYNC_A;
      STEP_SYNC_B:   emit_word = SYNC_B;
      STEP_PC:       emit_word = cur.pc;
      STEP_HDR_LAST: emit_word = cur.len_bits;
      STEP_DATA:     emit_word = cur.word;
      STEP_PAD: begin
        emit_word = '0;
        emit_rep  = cur.pad;
      end
      // stuffing words
      default:       emit_word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= STEP_HDR_FIRST;
    end else if (load) begin
      cur_valid <= q_any;
      step      <= load_step;
    end else if (emit) begin
      if (cur_final) begin
        cur_valid <= 1'b0;
      end else begin
        step <= step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word <= emit_word;
      out_rep  <= emit_rep;
      out_eor  <= cur_final;
      out_eob  <= cur_final && cur.last;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (step <= STEP_PAD))
    else $error("back end step out of range");

  a_eob_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_eob |-> out_eor)
    else $error("end of burst without end of run");

  a_rep_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_rep != '0))
    else $error("zero repeat count on a result");

  a_header_only_with_first: assert property (@(posedge clk) disable iff (rst)
    cur_valid && (step < STEP_DATA) |-> cur.first)
    else $error("header word for an item that does not open a frame");

endmodule
`default_nettype wire

// File: src/ac3_burst_framer_top.sv
// top level of the ac3 burst framer: front end, item queue, back end
// path: an accepted item is registered in the queue, in cur and at the output port
// throughput: one byte per cycle enters while the queue has room; results leave at
//   most one per cycle, held while m_tready is low; a frame start adds eight header
//   results and a frame end one padding result, buffered in QUEUE_DEPTH entries
// reset: synchronous rst clears position state, queue and output; pc_word = 1,
//   min_burst_bytes = 6144
`default_nettype none
module ac3_burst_framer_top
  import abf_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 8191,
  parameter int unsigned QUEUE_DEPTH     = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [WORD_W-1:0]     cfg_data,
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // data_byte[7:0], frame_bytes[20:8]
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  output      logic [OUT_DATA_W-1:0] m_tdata,   // word[15:0], repeat_count[29:16]
  output      logic                  m_tlast,   // end_of_burst
  output      logic                  m_tuser    // end_of_run
);

  abf_rec_t          push_rec;
  abf_rec_t          pop_rec;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  logic [WORD_W-1:0] out_word;
  logic [REP_W-1:0]  out_rep;

  abf_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .data_byte   (s_tdata[BYTE_W-1:0]),
    .frame_bytes (s_tdata[BYTE_W+LEN_W-1:BYTE_W]),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_rec       (push_rec)
  );

  abf_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_rec  (pop_rec)
  );

  abf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_rec     (pop_rec),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (out_word),
    .out_rep   (out_rep),
    .out_eob   (m_tlast),
    .out_eor   (m_tuser)
  );

  assign m_tdata = {2'b00, out_rep, out_word};

endmodule
`default_nettype wire
